>>> hdl/ucr_pkg.sv
// ucr_pkg: types, widths and constants for the ultrasonic echo ranger
// no dependencies; used by the interfaces and every module in hdl/
package ucr_pkg;

  localparam int FRAC_BITS    = 4;
  localparam int TICKS_PER_CM = 155;

  localparam int CNT_W  = 16;
  localparam int TRIG_W = 8;
  localparam int DIST_W = 14;
  localparam int Q_W    = 15;
  localparam int REM_W  = 10;
  localparam int IDX_W  = 2;
  localparam int DATA_W = 16;

  localparam int DIST_MAX_I  = (1 << DIST_W) - 1;
  localparam int RESET_RAW   = 100 << FRAC_BITS;
  localparam int TIMEOUT_RAW = 999 << FRAC_BITS;

  localparam logic [DIST_W-1:0] RESET_DIST =
    DIST_W'((RESET_RAW > DIST_MAX_I) ? DIST_MAX_I : RESET_RAW);
  localparam logic [DIST_W-1:0] TIMEOUT_DIST =
    DIST_W'((TIMEOUT_RAW > DIST_MAX_I) ? DIST_MAX_I : TIMEOUT_RAW);
  localparam logic [DIST_W:0] DIST_MAX = (DIST_W+1)'(DIST_MAX_I);

  // per-tick quotient and remainder step of (count << FRAC_BITS) / TICKS_PER_CM
  localparam logic [Q_W:0]   Q_STEP  = (Q_W+1)'((1 << FRAC_BITS) / TICKS_PER_CM);
  localparam logic [REM_W:0] R_STEP  = (REM_W+1)'((1 << FRAC_BITS) % TICKS_PER_CM);
  localparam logic [REM_W:0] R_DIV   = (REM_W+1)'(TICKS_PER_CM);
  localparam logic [Q_W:0]   Q_MAX   = (Q_W+1)'((1 << Q_W) - 1);

  localparam logic [IDX_W-1:0] REG_WAIT_LIMIT    = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH_LIMIT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_TRIGGER_TICKS = 2'd2;

  localparam logic [CNT_W-1:0]  WAIT_LIMIT_RST    = 16'd30000;
  localparam logic [CNT_W-1:0]  WIDTH_LIMIT_RST   = 16'd25000;
  localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST = 8'd10;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT,
    PH_WIDTH
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0]  wait_limit;
    logic [CNT_W-1:0]  width_limit;
    logic [TRIG_W-1:0] trigger_ticks;
  } cfg_t;

  typedef struct packed {
    logic cmd;
    logic echo;
  } item_t;

endpackage

>>> hdl/ucr_if.sv
// ucr_if: valid/ready channel interfaces for requests, results and register writes
// depends on ucr_pkg
interface ucr_item_if import ucr_pkg::*;;
  logic valid;
  logic ready;
  logic cmd;
  logic echo;
  modport source(output valid, cmd, echo, input ready);
  modport sink(input valid, cmd, echo, output ready);
endinterface

interface ucr_result_if import ucr_pkg::*;;
  logic              valid;
  logic              ready;
  logic              trigger;
  logic [DIST_W-1:0] distance;
  logic              done_res;
  logic              timed_out;
  logic              busy_res;
  modport source(output valid, trigger, distance, done_res, timed_out, busy_res, input ready);
  modport sink(input valid, trigger, distance, done_res, timed_out, busy_res, output ready);
endinterface

interface ucr_cfg_if import ucr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> hdl/ultrasonic_echo_ranger_core.sv
// ultrasonic_echo_ranger_core: top level of the ultrasonic echo ranger
// depends on ucr_pkg, ucr_if, ucr_cfg, ucr_in_reg, ucr_step
//
// channels: item carries one request (cmd = 0 one microsecond tick with the
// sampled echo level, cmd = 1 start a measurement); result carries one
// response per request (trigger level, filtered distance in cm with
// FRAC_BITS fraction bits, done, timeout, busy); cfg writes the wait limit,
// width limit and trigger length registers, always ready
// path: an accepted request is held in the input register, then goes through
// the step logic into the result register, from which it can be taken
// throughput: one request per cycle while results are taken; the distance
// quotient is kept as a running quotient/remainder during the echo high time,
// so each request is one pass through the step logic between the input and result registers
// reset: idle, tick count zero, filtered distance 100 cm, limits 30000 and
// 25000 ticks, trigger length 10 ticks; no clearing pass
// receiver stall: the result register holds, the input register takes one
// more request, then item ready drops until the result is taken
// config writes only while no request is outstanding (user rule, not enforced)
module ultrasonic_echo_ranger_core import ucr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ucr_item_if.sink      item,
  ucr_result_if.source  result,
  ucr_cfg_if.sink       cfg
);

  cfg_t  regs;
  logic  advance;
  logic  req_valid;
  item_t req;

  ucr_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ucr_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req)
  );

  ucr_step u_step (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .req_valid (req_valid),
    .req       (req),
    .advance   (advance),
    .result    (result)
  );

endmodule

>>> hdl/ucr_cfg.sv
// ucr_cfg: limit and trigger length registers written through the config channel
// depends on ucr_pkg, ucr_if
module ucr_cfg import ucr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ucr_cfg_if.sink   cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.wait_limit    <= WAIT_LIMIT_RST;
      regs.width_limit   <= WIDTH_LIMIT_RST;
      regs.trigger_ticks <= TRIGGER_TICKS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WAIT_LIMIT:    regs.wait_limit    <= cfg.data;
        REG_WIDTH_LIMIT:   regs.width_limit   <= cfg.data;
        REG_TRIGGER_TICKS: regs.trigger_ticks <= cfg.data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/ucr_in_reg.sv
// ucr_in_reg: input register stage for requests
// depends on ucr_pkg, ucr_if
module ucr_in_reg import ucr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ucr_item_if.sink  item,
  input  logic      advance,
  output logic      req_valid,
  output item_t     req
);

  assign item.ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (item.ready) begin
      req_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      req.cmd  <= item.cmd;
      req.echo <= item.echo;
    end
  end

endmodule

>>> hdl/ucr_step.sv
// ucr_step: measurement state machine, running distance quotient, filter and result register
// depends on ucr_pkg, ucr_if
module ucr_step import ucr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        regs,
  input  logic        req_valid,
  input  item_t       req,
  output logic        advance,
  ucr_result_if.source result
);

  phase_t             phase, phase_next;
  logic [CNT_W-1:0]   tick_count, tick_count_next;
  logic [Q_W-1:0]     quot, quot_next;
  logic [REM_W-1:0]   rem, rem_next;
  logic [DIST_W-1:0]  filt, filt_next;
  logic               done, tmo;
  logic               res_trigger, res_busy;
  logic [CNT_W-1:0]   trig_inc;
  logic [Q_W:0]       q_base, q_sum;
  logic [REM_W:0]     r_sum;
  logic               from_zero;
  logic [DIST_W+1:0]  avg_sum;
  logic [DIST_W:0]    avg;

  assign advance = req_valid && (!result.valid || result.ready);

  // quotient/remainder of (count << FRAC_BITS) / TICKS_PER_CM, one count further
  always_comb begin
    q_base = from_zero ? '0 : {1'b0, quot};
    r_sum  = (from_zero ? '0 : {1'b0, rem}) + R_STEP;
    q_sum  = q_base + Q_STEP;
    if (r_sum >= R_DIV) begin
      r_sum = r_sum - R_DIV;
      q_sum = q_sum + 1'b1;
    end
    if (q_sum > Q_MAX) begin
      q_sum = Q_MAX;
    end
  end

  assign avg_sum  = {2'b0, filt} + {1'b0, quot};
  assign avg      = (avg_sum[DIST_W+1:1] > DIST_MAX) ? DIST_MAX : avg_sum[DIST_W+1:1];
  assign trig_inc = tick_count + 1'b1;

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    quot_next       = quot;
    rem_next        = rem;
    filt_next       = filt;
    done            = 1'b0;
    tmo             = 1'b0;
    from_zero       = 1'b0;
    if (req.cmd) begin
      if (phase == PH_IDLE) begin
        phase_next      = PH_TRIG;
        tick_count_next = '0;
      end
    end else begin
      unique case (phase)
        PH_IDLE: ;
        PH_TRIG: begin
          if (trig_inc >= {{(CNT_W-TRIG_W){1'b0}}, regs.trigger_ticks}) begin
            phase_next      = PH_WAIT;
            tick_count_next = '0;
          end else begin
            tick_count_next = trig_inc;
          end
        end
        PH_WAIT: begin
          if (req.echo) begin
            from_zero = 1'b1;
            if (regs.width_limit == '0) begin
              tmo = 1'b1;
            end else begin
              phase_next      = PH_WIDTH;
              tick_count_next = CNT_W'(1);
              quot_next       = q_sum[Q_W-1:0];
              rem_next        = r_sum[REM_W-1:0];
            end
          end else if (tick_count >= regs.wait_limit) begin
            tmo = 1'b1;
          end else begin
            tick_count_next = tick_count + 1'b1;
          end
        end
        PH_WIDTH: begin
          if (req.echo) begin
            if (tick_count >= regs.width_limit) begin
              tmo = 1'b1;
            end else begin
              tick_count_next = tick_count + 1'b1;
              quot_next       = q_sum[Q_W-1:0];
              rem_next        = r_sum[REM_W-1:0];
            end
          end else begin
            filt_next = avg[DIST_W-1:0];
            done      = 1'b1;
          end
        end
        default: ;
      endcase
      if (tmo) begin
        filt_next = TIMEOUT_DIST;
        done      = 1'b1;
      end
      if (done) begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    end
  end

  always_comb begin
    res_trigger = (phase_next == PH_TRIG);
    res_busy    = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      filt       <= RESET_DIST;
    end else if (advance) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      filt       <= filt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.trigger   <= res_trigger;
      result.distance  <= filt_next;
      result.done_res  <= done;
      result.timed_out <= tmo;
      result.busy_res  <= res_busy;
    end
  end

endmodule
